[rtl/core/kmht_pkg.sv]
package kmht_pkg;

    localparam int CAPACITY  = 64;
    localparam int ID_COUNT  = 1024;
    localparam int TIME_BITS = 48;

    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = IDX_W + 1;
    localparam int CHILD_W   = IDX_W + 2;
    localparam int ID_W      = 10;
    localparam int TMO_W     = 31;
    localparam int EL_W      = 16;
    localparam int KIND_W    = 3;
    localparam int RES_LIMIT = 64;
    localparam int K_W       = $clog2(RES_LIMIT);

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_ADJUST = 3'd1;
    localparam logic [2:0] OP_FIRE   = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [KIND_W-1:0] K_EXPIRED = 3'd0;
    localparam logic [KIND_W-1:0] K_FIRED   = 3'd1;
    localparam logic [KIND_W-1:0] K_ACK     = 3'd2;
    localparam logic [KIND_W-1:0] K_NEXT    = 3'd3;
    localparam logic [KIND_W-1:0] K_ERROR   = 3'd4;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef struct packed {
        time_t            expiry;
        logic [ID_W-1:0]  id;
    } slot_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        slot_t             wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr_a;
        logic [IDX_W-1:0]  raddr_b;
    } heap_req_t;

    typedef struct packed {
        logic              we;
        logic [ID_W-1:0]   waddr;
        logic [IDX_W-1:0]  wdata;
        logic              re;
        logic [ID_W-1:0]   raddr;
    } slot_req_t;

    // Saturating add of a 31-bit offset to a time value.
    function automatic time_t sat_add(time_t a, logic [TMO_W-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + (TIME_BITS + 1)'(b);
        return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
    endfunction

endpackage

[rtl/core/kmht_heap_mem.sv]
module kmht_heap_mem import kmht_pkg::*; (
    input  logic      aclk,
    input  heap_req_t req,
    output slot_t     rd_a,
    output slot_t     rd_b
);

    slot_t mem [CAPACITY];
    slot_t rd_a_reg;
    slot_t rd_b_reg;

    // Two read ports, one write port, registered read data.
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rd_a_reg <= mem[req.raddr_a];
            rd_b_reg <= mem[req.raddr_b];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

[rtl/core/kmht_slot_mem.sv]
module kmht_slot_mem import kmht_pkg::*; (
    input  logic             aclk,
    input  slot_req_t        req,
    output logic [IDX_W-1:0] rd
);

    logic [IDX_W-1:0] mem [ID_COUNT];
    logic [IDX_W-1:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rd_reg <= mem[req.raddr];
        end
    end

    assign rd = rd_reg;

endmodule

[rtl/core/kmht_ctrl.sv]
module kmht_ctrl import kmht_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_opcode,
    input  logic [ID_W-1:0]   s_timer_id,
    input  logic [TMO_W-1:0]  s_timeout_ms,
    input  logic [EL_W-1:0]   s_elapsed_ms,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [KIND_W-1:0] m_result_kind,
    output logic [ID_W-1:0]   m_timer_id_res,
    output logic [TMO_W-1:0]  m_next_ms,
    output logic              m_has_next,
    output logic              m_last,
    output heap_req_t         heap_req,
    input  slot_t             heap_rd_a,
    input  slot_t             heap_rd_b,
    output slot_req_t         slot_req,
    input  logic [IDX_W-1:0]  slot_rd
);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_LOOK1  = 13'b0000000000010,
        ST_LOOK2  = 13'b0000000000100,
        ST_REM_RD = 13'b0000000001000,
        ST_REM_EV = 13'b0000000010000,
        ST_DN_RD  = 13'b0000000100000,
        ST_DN_EV  = 13'b0000001000000,
        ST_UP_RD  = 13'b0000010000000,
        ST_UP_EV  = 13'b0000100000000,
        ST_PLACE  = 13'b0001000000000,
        ST_TK_RD  = 13'b0010000000000,
        ST_TK_EV  = 13'b0100000000000,
        ST_RESP   = 13'b1000000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         op_reg, op_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [TMO_W-1:0]   tmo_reg, tmo_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    time_t              now_reg, now_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    slot_t              cur_reg, cur_next;
    logic               moved_reg, moved_next;
    logic               up_ok_reg, up_ok_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [KIND_W-1:0]  rkind_reg, rkind_next;
    logic [ID_W-1:0]    rid_reg, rid_next;
    logic [TMO_W-1:0]   rnext_reg, rnext_next;
    logic               rhas_reg, rhas_next;

    logic               m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]  m_kind_reg, m_kind_next;
    logic [ID_W-1:0]    m_id_reg, m_id_next;
    logic [TMO_W-1:0]   m_nms_reg, m_nms_next;
    logic               m_flag_reg, m_flag_next;
    logic               m_last_reg, m_last_next;

    logic               emit_ok;
    logic [CHILD_W-1:0] c_w, c1_w;
    logic [CNT_W-1:0]   n_rm;
    logic               present;
    logic               use_r;
    slot_t              ch;
    time_t              diff;

    assign s_ready = (state_reg == ST_IDLE);
    assign emit_ok = !m_valid_reg || m_ready;
    assign c_w     = CHILD_W'({idx_reg, 1'b1});
    assign c1_w    = c_w + 1'b1;
    assign n_rm    = count_reg - 1'b1;
    assign present = (CNT_W'(idx_reg) < count_reg) && (heap_rd_a.id == id_reg);
    assign use_r   = (c1_w < CHILD_W'(count_reg)) && (heap_rd_b.expiry < heap_rd_a.expiry);
    assign ch      = use_r ? heap_rd_b : heap_rd_a;
    assign diff    = (heap_rd_a.expiry > now_reg) ? heap_rd_a.expiry - now_reg : '0;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        id_next      = id_reg;
        tmo_next     = tmo_reg;
        count_next   = count_reg;
        now_next     = now_reg;
        idx_next     = idx_reg;
        cur_next     = cur_reg;
        moved_next   = moved_reg;
        up_ok_next   = up_ok_reg;
        k_next       = k_reg;
        rkind_next   = rkind_reg;
        rid_next     = rid_reg;
        rnext_next   = rnext_reg;
        rhas_next    = rhas_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_id_next    = m_id_reg;
        m_nms_next   = m_nms_reg;
        m_flag_next  = m_flag_reg;
        m_last_next  = m_last_reg;
        heap_req     = '0;
        slot_req     = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_opcode;
                    id_next    = s_timer_id;
                    tmo_next   = s_timeout_ms;
                    rkind_next = K_ACK;
                    rid_next   = '0;
                    rnext_next = '0;
                    rhas_next  = 1'b0;
                    case (s_opcode)
                        OP_ADD, OP_ADJUST, OP_FIRE: begin
                            if ((ID_W + 1)'(s_timer_id) < (ID_W + 1)'(ID_COUNT)) begin
                                slot_req.re    = 1'b1;
                                slot_req.raddr = s_timer_id;
                                state_next     = ST_LOOK1;
                            end else begin
                                rkind_next = K_ERROR;
                                state_next = ST_RESP;
                            end
                        end
                        OP_TICK: begin
                            now_next   = sat_add(now_reg, TMO_W'(s_elapsed_ms));
                            k_next     = '0;
                            state_next = ST_TK_RD;
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                            state_next = ST_RESP;
                        end
                        default: begin
                            rkind_next = K_ERROR;
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_LOOK1: begin
                heap_req.re      = 1'b1;
                heap_req.raddr_a = slot_rd;
                idx_next         = slot_rd;
                state_next       = ST_LOOK2;
            end
            ST_LOOK2: begin
                moved_next = 1'b0;
                cur_next   = '{expiry: sat_add(now_reg, tmo_reg), id: id_reg};
                case (op_reg)
                    OP_ADD: begin
                        if (present) begin
                            up_ok_next = 1'b1;
                            state_next = ST_DN_RD;
                        end else if (count_reg >= CNT_W'(CAPACITY)) begin
                            rkind_next = K_ERROR;
                            state_next = ST_RESP;
                        end else begin
                            idx_next   = count_reg[IDX_W-1:0];
                            count_next = count_reg + 1'b1;
                            state_next = ST_UP_RD;
                        end
                    end
                    OP_ADJUST: begin
                        if (present) begin
                            up_ok_next = 1'b0;
                            state_next = ST_DN_RD;
                        end else begin
                            rkind_next = K_ERROR;
                            state_next = ST_RESP;
                        end
                    end
                    default: begin
                        if (present) begin
                            rkind_next = K_FIRED;
                            rid_next   = id_reg;
                            count_next = n_rm;
                            up_ok_next = 1'b1;
                            state_next = (CNT_W'(idx_reg) < n_rm) ? ST_REM_RD : ST_RESP;
                        end else begin
                            state_next = ST_RESP;
                        end
                    end
                endcase
            end
            ST_REM_RD: begin
                // The last entry fills the hole left by the removed one.
                heap_req.re      = 1'b1;
                heap_req.raddr_a = count_reg[IDX_W-1:0];
                state_next       = ST_REM_EV;
            end
            ST_REM_EV: begin
                cur_next   = heap_rd_a;
                moved_next = 1'b0;
                state_next = ST_DN_RD;
            end
            ST_DN_RD: begin
                if (c_w < CHILD_W'(count_reg)) begin
                    heap_req.re      = 1'b1;
                    heap_req.raddr_a = c_w[IDX_W-1:0];
                    heap_req.raddr_b = c1_w[IDX_W-1:0];
                    state_next       = ST_DN_EV;
                end else begin
                    state_next = (up_ok_reg && !moved_reg) ? ST_UP_RD : ST_PLACE;
                end
            end
            ST_DN_EV: begin
                if (cur_reg.expiry < ch.expiry) begin
                    state_next = (up_ok_reg && !moved_reg) ? ST_UP_RD : ST_PLACE;
                end else begin
                    heap_req.we    = 1'b1;
                    heap_req.waddr = idx_reg;
                    heap_req.wdata = ch;
                    slot_req.we    = 1'b1;
                    slot_req.waddr = ch.id;
                    slot_req.wdata = idx_reg;
                    idx_next       = use_r ? c1_w[IDX_W-1:0] : c_w[IDX_W-1:0];
                    moved_next     = 1'b1;
                    state_next     = ST_DN_RD;
                end
            end
            ST_UP_RD: begin
                if (idx_reg != '0) begin
                    heap_req.re      = 1'b1;
                    heap_req.raddr_a = (idx_reg - 1'b1) >> 1;
                    state_next       = ST_UP_EV;
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_UP_EV: begin
                if (heap_rd_a.expiry < cur_reg.expiry) begin
                    state_next = ST_PLACE;
                end else begin
                    heap_req.we    = 1'b1;
                    heap_req.waddr = idx_reg;
                    heap_req.wdata = heap_rd_a;
                    slot_req.we    = 1'b1;
                    slot_req.waddr = heap_rd_a.id;
                    slot_req.wdata = idx_reg;
                    idx_next       = (idx_reg - 1'b1) >> 1;
                    state_next     = ST_UP_RD;
                end
            end
            ST_PLACE: begin
                heap_req.we    = 1'b1;
                heap_req.waddr = idx_reg;
                heap_req.wdata = cur_reg;
                slot_req.we    = 1'b1;
                slot_req.waddr = cur_reg.id;
                slot_req.wdata = idx_reg;
                state_next     = (op_reg == OP_TICK) ? ST_TK_RD : ST_RESP;
            end
            ST_TK_RD: begin
                heap_req.re      = 1'b1;
                heap_req.raddr_a = '0;
                state_next       = ST_TK_EV;
            end
            ST_TK_EV: begin
                if (count_reg != '0 && k_reg < K_W'(RES_LIMIT - 1)
                        && heap_rd_a.expiry <= now_reg) begin
                    if (emit_ok) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = K_EXPIRED;
                        m_id_next    = heap_rd_a.id;
                        m_nms_next   = '0;
                        m_flag_next  = 1'b0;
                        m_last_next  = 1'b0;
                        k_next       = k_reg + 1'b1;
                        count_next   = n_rm;
                        idx_next     = '0;
                        up_ok_next   = 1'b1;
                        state_next   = (n_rm != '0) ? ST_REM_RD : ST_TK_RD;
                    end
                end else begin
                    rkind_next = K_NEXT;
                    if (count_reg == '0) begin
                        rnext_next = '0;
                        rhas_next  = 1'b0;
                    end else begin
                        rnext_next = (diff[TIME_BITS-1:TMO_W] != '0) ? '1 : diff[TMO_W-1:0];
                        rhas_next  = 1'b1;
                    end
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (emit_ok) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = rkind_reg;
                    m_id_next    = rid_reg;
                    m_nms_next   = rnext_reg;
                    m_flag_next  = rhas_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            now_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            now_reg     <= now_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        tmo_reg    <= tmo_next;
        idx_reg    <= idx_next;
        cur_reg    <= cur_next;
        moved_reg  <= moved_next;
        up_ok_reg  <= up_ok_next;
        k_reg      <= k_next;
        rkind_reg  <= rkind_next;
        rid_reg    <= rid_next;
        rnext_reg  <= rnext_next;
        rhas_reg   <= rhas_next;
        m_kind_reg <= m_kind_next;
        m_id_reg   <= m_id_next;
        m_nms_reg  <= m_nms_next;
        m_flag_reg <= m_flag_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = m_kind_reg;
    assign m_timer_id_res = m_id_reg;
    assign m_next_ms      = m_nms_reg;
    assign m_has_next     = m_flag_reg;
    assign m_last         = m_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("heap count exceeds capacity");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != ST_IDLE)
        else $error("transaction accepted but sequencer stayed idle");

    a_write_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        heap_req.we |-> CNT_W'(heap_req.waddr) < count_reg)
        else $error("heap write beyond live entries");

    a_nonlast_is_expired: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_result_kind == K_EXPIRED)
        else $error("non-final result is not an expiry");
`endif

endmodule

[rtl/core/keyed_min_heap_timer_core.sv]
// One transaction at a time: s_ready is high only in the idle state. Clear and unknown
// opcodes go straight to the response; add, adjust and fire read the id's slot and its
// heap entry, then sift one heap level per compare, and a fire that moves the last entry
// reads it first. A tick removes and sifts each expired timer in turn before its final
// report. Reset (aresetn, synchronous, active low) empties the heap and zeroes the time
// counter; memories are not swept, so the block is ready right away.
module keyed_min_heap_timer_core import kmht_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_opcode,
    input  logic [ID_W-1:0]   s_timer_id,
    input  logic [TMO_W-1:0]  s_timeout_ms,
    input  logic [EL_W-1:0]   s_elapsed_ms,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [KIND_W-1:0] m_result_kind,
    output logic [ID_W-1:0]   m_timer_id_res,
    output logic [TMO_W-1:0]  m_next_ms,
    output logic              m_has_next,
    output logic              m_last
);

    // The heap memory holds expiry and id per slot. The slot memory maps an id to
    // its heap slot; an id counts as present only when its slot lies below the
    // live count and that slot holds the same id, so no presence bits are kept.
    heap_req_t        heap_req;
    slot_t            heap_rd_a;
    slot_t            heap_rd_b;
    slot_req_t        slot_req;
    logic [IDX_W-1:0] slot_rd;

    kmht_heap_mem u_heap (
        .aclk (aclk),
        .req  (heap_req),
        .rd_a (heap_rd_a),
        .rd_b (heap_rd_b)
    );

    kmht_slot_mem u_slot (
        .aclk (aclk),
        .req  (slot_req),
        .rd   (slot_rd)
    );

    // The sequencer sifts with a moving hole: displaced entries are written back
    // one level at a time and the moving entry is written once at its final slot.
    kmht_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_timer_id     (s_timer_id),
        .s_timeout_ms   (s_timeout_ms),
        .s_elapsed_ms   (s_elapsed_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_timer_id_res (m_timer_id_res),
        .m_next_ms      (m_next_ms),
        .m_has_next     (m_has_next),
        .m_last         (m_last),
        .heap_req       (heap_req),
        .heap_rd_a      (heap_rd_a),
        .heap_rd_b      (heap_rd_b),
        .slot_req       (slot_req),
        .slot_rd        (slot_rd)
    );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import kmht_pkg::*;

    // Unknown opcodes: everything above clear must come back as an error.
    localparam logic [2:0] OP_BAD_FIRST = 3'd5;
    localparam logic [2:0] OP_BAD_LAST  = 3'd7;

    // Largest number of expirations reported by one tick before the final report.
    localparam int EXPIRE_CAP   = RES_LIMIT - 1;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_ITEMS = 51;

    // One result transaction, as seen on the m_ port group.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [TMO_W-1:0]  nxt;
        logic              has;
        logic              last;
    } outcome_t;

    // One row of the directed script. When typed is set, the single result is
    // written out here and the predictor only keeps its state in step.
    typedef struct packed {
        logic [2:0]        op;
        logic [ID_W-1:0]   id;
        logic [TMO_W-1:0]  tmo;
        logic [EL_W-1:0]   el;
        logic              typed;
        logic [KIND_W-1:0] kind;
    } script_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [2:0]        s_opcode = OP_CLEAR;
    logic [ID_W-1:0]   s_timer_id = '0;
    logic [TMO_W-1:0]  s_timeout_ms = '0;
    logic [EL_W-1:0]   s_elapsed_ms = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [KIND_W-1:0] m_result_kind;
    logic [ID_W-1:0]   m_timer_id_res;
    logic [TMO_W-1:0]  m_next_ms;
    logic              m_has_next;
    logic              m_last;

    keyed_min_heap_timer_core uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_timer_id     (s_timer_id),
        .s_timeout_ms   (s_timeout_ms),
        .s_elapsed_ms   (s_elapsed_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_timer_id_res (m_timer_id_res),
        .m_next_ms      (m_next_ms),
        .m_has_next     (m_has_next),
        .m_last         (m_last)
    );

    // 12 ns clock period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Mirror of the timer store: a min-heap by expiry plus an id-to-slot table.
    logic [TIME_BITS-1:0] heap_exp [CAPACITY];
    logic [ID_W-1:0]      heap_id  [CAPACITY];
    int                   slot_of  [ID_COUNT];
    bit                   armed    [ID_COUNT];
    int                   live_count;
    logic [TIME_BITS-1:0] clock_ms;

    // Results still owed by the block, oldest first.
    outcome_t owed_results [$];

    int err_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycle_count = 0;

    // Time arithmetic saturates at the top of the counter range.
    function automatic logic [TIME_BITS-1:0] later_by(logic [TIME_BITS-1:0] base,
                                                      logic [TMO_W-1:0] delta);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, base} + {{(TIME_BITS + 1 - TMO_W){1'b0}}, delta};
        return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
    endfunction

    function automatic void swap_entries(int a, int b);
        logic [TIME_BITS-1:0] e;
        logic [ID_W-1:0]      t;
        e = heap_exp[a];
        t = heap_id[a];
        heap_exp[a] = heap_exp[b];
        heap_id[a] = heap_id[b];
        heap_exp[b] = e;
        heap_id[b] = t;
        slot_of[heap_id[a]] = a;
        slot_of[heap_id[b]] = b;
    endfunction

    // An entry climbs past any parent that is not strictly earlier.
    function automatic void bubble_up(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (heap_exp[p] < heap_exp[i])
                break;
            swap_entries(i, p);
            i = p;
        end
    endfunction

    // The right child wins only when strictly earlier; the entry sinks unless
    // it is strictly earlier than that child. Returns whether it moved.
    function automatic bit bubble_down(int start, int n);
        int i;
        int c;
        i = start;
        c = 2 * i + 1;
        while (c < n) begin
            if (c + 1 < n && heap_exp[c + 1] < heap_exp[c])
                c++;
            if (heap_exp[i] < heap_exp[c])
                break;
            swap_entries(i, c);
            i = c;
            c = 2 * i + 1;
        end
        return i > start;
    endfunction

    function automatic void take_out(int idx);
        int n;
        n = live_count - 1;
        if (idx < n) begin
            swap_entries(idx, n);
            if (!bubble_down(idx, n))
                bubble_up(idx);
        end
        armed[heap_id[n]] = 1'b0;
        live_count = n;
    endfunction

    function automatic void owe(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                logic [TMO_W-1:0] nxt, logic has);
        outcome_t row;
        row = '{kind: kind, id: id, nxt: nxt, has: has, last: 1'b0};
        owed_results.insert(owed_results.size(), row);
    endfunction

    // Advances the mirror by one accepted transaction and queues its results.
    function automatic void predict_timer_op(logic [2:0] op, logic [ID_W-1:0] id,
                                             logic [TMO_W-1:0] tmo, logic [EL_W-1:0] el);
        int                   k;
        logic [ID_W-1:0]      fid;
        logic [TIME_BITS-1:0] gap;
        case (op)
            OP_ADD: begin
                if (armed[id]) begin
                    heap_exp[slot_of[id]] = later_by(clock_ms, tmo);
                    if (!bubble_down(slot_of[id], live_count))
                        bubble_up(slot_of[id]);
                    owe(K_ACK, '0, '0, 1'b0);
                end else if (live_count >= CAPACITY) begin
                    owe(K_ERROR, '0, '0, 1'b0);
                end else begin
                    heap_exp[live_count] = later_by(clock_ms, tmo);
                    heap_id[live_count] = id;
                    slot_of[id] = live_count;
                    armed[id] = 1'b1;
                    live_count++;
                    bubble_up(live_count - 1);
                    owe(K_ACK, '0, '0, 1'b0);
                end
            end
            OP_ADJUST: begin
                // Adjust only ever sinks the entry, even when it got earlier.
                if (!armed[id]) begin
                    owe(K_ERROR, '0, '0, 1'b0);
                end else begin
                    heap_exp[slot_of[id]] = later_by(clock_ms, tmo);
                    void'(bubble_down(slot_of[id], live_count));
                    owe(K_ACK, '0, '0, 1'b0);
                end
            end
            OP_FIRE: begin
                if (!armed[id] || live_count == 0) begin
                    owe(K_ACK, '0, '0, 1'b0);
                end else begin
                    take_out(slot_of[id]);
                    owe(K_FIRED, id, '0, 1'b0);
                end
            end
            OP_TICK: begin
                clock_ms = later_by(clock_ms, {{(TMO_W - EL_W){1'b0}}, el});
                k = 0;
                while (live_count > 0 && k < EXPIRE_CAP && heap_exp[0] <= clock_ms) begin
                    fid = heap_id[0];
                    take_out(0);
                    owe(K_EXPIRED, fid, '0, 1'b0);
                    k++;
                end
                if (live_count == 0) begin
                    owe(K_NEXT, '0, '0, 1'b0);
                end else begin
                    // Timers left over by the per-tick cap report a gap of zero.
                    gap = heap_exp[0] > clock_ms ? heap_exp[0] - clock_ms : '0;
                    if (gap > {{(TIME_BITS - TMO_W){1'b0}}, {TMO_W{1'b1}}})
                        gap = {{(TIME_BITS - TMO_W){1'b0}}, {TMO_W{1'b1}}};
                    owe(K_NEXT, '0, gap[TMO_W-1:0], 1'b1);
                end
            end
            OP_CLEAR: begin
                foreach (armed[j])
                    armed[j] = 1'b0;
                live_count = 0;
                owe(K_ACK, '0, '0, 1'b0);
            end
            default: owe(K_ERROR, '0, '0, 1'b0);
        endcase
        owed_results[$].last = 1'b1;
    endfunction

    // Presents one transaction and holds it until the block takes it.
    task automatic send_op(input logic [2:0] op, input logic [ID_W-1:0] id,
                           input logic [TMO_W-1:0] tmo, input logic [EL_W-1:0] el,
                           input logic typed, input logic [KIND_W-1:0] kind);
        int       before_size;
        outcome_t row;
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_timer_id <= id;
        s_timeout_ms <= tmo;
        s_elapsed_ms <= el;
        do
            @(posedge aclk);
        while (!s_ready);
        before_size = owed_results.size();
        predict_timer_op(op, id, tmo, el);
        if (typed) begin
            // Typed rows are single-result operations; replace the prediction.
            while (owed_results.size() > before_size)
                owed_results.delete(owed_results.size() - 1);
            row = '{kind: kind, id: '0, nxt: '0, has: 1'b0, last: 1'b1};
            owed_results.insert(owed_results.size(), row);
        end
    endtask

    // Sender holds off until every owed result has been delivered.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Fills the heap to capacity with near-simultaneous expiries, so that one
    // tick runs into the per-tick expiration cap.
    task automatic fill_and_flush();
        send_op(OP_CLEAR, '0, '0, '0, 1'b1, K_ACK);
        for (int n = 0; n < CAPACITY; n++)
            send_op(OP_ADD, ID_W'(100 + n), TMO_W'($urandom_range(3)), '0, 1'b0, '0);
        send_op(OP_ADD, ID_W'(200), TMO_W'(5), '0, 1'b1, K_ERROR);
        send_op(OP_ADD, ID_W'(100), TMO_W'(2), '0, 1'b1, K_ACK);
        send_op(OP_TICK, '0, '0, EL_W'(10), 1'b0, '0);
        send_op(OP_TICK, '0, '0, '0, 1'b0, '0);
    endtask

    // Random traffic: mostly a small id pool so fire and adjust hit live timers.
    task automatic random_traffic(input int count);
        logic [2:0]       op;
        logic [ID_W-1:0]  id;
        logic [TMO_W-1:0] tmo;
        logic [EL_W-1:0]  el;
        int               pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 35)      op = OP_ADD;
            else if (pick < 50) op = OP_ADJUST;
            else if (pick < 65) op = OP_FIRE;
            else if (pick < 90) op = OP_TICK;
            else if (pick < 94) op = OP_CLEAR;
            else                op = 3'($urandom_range(OP_BAD_LAST, OP_BAD_FIRST));
            id = ($urandom_range(9) == 0) ? ID_W'($urandom_range(ID_COUNT - 1))
                                          : ID_W'($urandom_range(63, 16));
            tmo = ($urandom_range(7) == 0) ? TMO_W'($urandom) : TMO_W'($urandom_range(3000));
            el = ($urandom_range(7) == 0) ? EL_W'($urandom_range(65535))
                                          : EL_W'($urandom_range(400));
            send_op(op, id, tmo, el, 1'b0, '0);
        end
    endtask

    // Receiver: stalls at random, and checks every accepted result transaction
    // against the oldest owed one.
    always @(posedge aclk) begin
        outcome_t want;
        m_ready <= aresetn && ($urandom_range(99) >= rx_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                $error("unexpected result: kind %0d id %0d", m_result_kind, m_timer_id_res);
                err_count++;
            end else begin
                want = owed_results.pop_front();
                if (m_result_kind !== want.kind) begin
                    $error("result_kind: expected %0d, got %0d", want.kind, m_result_kind);
                    err_count++;
                end
                if (m_timer_id_res !== want.id) begin
                    $error("timer_id_res: expected %0d, got %0d", want.id, m_timer_id_res);
                    err_count++;
                end
                if (m_next_ms !== want.nxt) begin
                    $error("next_ms: expected %0d, got %0d", want.nxt, m_next_ms);
                    err_count++;
                end
                if (m_has_next !== want.has) begin
                    $error("has_next: expected %0d, got %0d", want.has, m_has_next);
                    err_count++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_last);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Directed script: empty-store report, error paths, range extremes, ties,
    // re-arm, fire of live and absent timers, and clear.
    script_row_t script [20] = '{
        '{OP_TICK,   10'd0,    31'd0,          16'd0,     1'b1, K_NEXT},
        '{OP_FIRE,   10'd5,    31'd0,          16'd0,     1'b1, K_ACK},
        '{OP_ADJUST, 10'd5,    31'd9,          16'd0,     1'b1, K_ERROR},
        '{3'd5,      10'd0,    31'd0,          16'd0,     1'b1, K_ERROR},
        '{3'd6,      10'd1023, 31'h7FFFFFFF,   16'hFFFF,  1'b1, K_ERROR},
        '{3'd7,      10'd0,    31'd0,          16'd0,     1'b1, K_ERROR},
        '{OP_ADD,    10'd0,    31'd0,          16'd0,     1'b1, K_ACK},
        '{OP_ADD,    10'd1023, 31'h7FFFFFFF,   16'd0,     1'b1, K_ACK},
        '{OP_ADD,    10'd512,  31'd100,        16'd0,     1'b1, K_ACK},
        '{OP_TICK,   10'd0,    31'd0,          16'd0,     1'b0, K_NEXT},
        '{OP_ADD,    10'd512,  31'd50,         16'd0,     1'b0, K_ACK},
        '{OP_ADJUST, 10'd1023, 31'd10,         16'd0,     1'b0, K_ACK},
        '{OP_ADD,    10'd7,    31'd10,         16'd0,     1'b0, K_ACK},
        '{OP_ADD,    10'd8,    31'd10,         16'd0,     1'b0, K_ACK},
        '{OP_TICK,   10'd0,    31'd0,          16'hFFFF,  1'b0, K_NEXT},
        '{OP_ADD,    10'd300,  31'd5,          16'd0,     1'b0, K_ACK},
        '{OP_FIRE,   10'd300,  31'd0,          16'd0,     1'b0, K_FIRED},
        '{OP_ADD,    10'd682,  31'h2AAAAAAA,   16'd0,     1'b0, K_ACK},
        '{OP_CLEAR,  10'd0,    31'd0,          16'd0,     1'b1, K_ACK},
        '{OP_TICK,   10'd0,    31'd0,          16'h5555,  1'b1, K_NEXT}
    };

    initial begin
        foreach (armed[j])
            armed[j] = 1'b0;
        live_count = 0;
        clock_ms = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Three idle profiles: sender-heavy, receiver-heavy, then none.
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 47 : 0;
            rx_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 38 : 0;
            if (phase == 0) begin
                foreach (script[r])
                    send_op(script[r].op, script[r].id, script[r].tmo, script[r].el,
                            script[r].typed, script[r].kind);
            end
            fill_and_flush();
            random_traffic(RANDOM_ITEMS);
            wait_for_drain();
        end

        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
rtl/core/kmht_pkg.sv
rtl/core/kmht_heap_mem.sv
rtl/core/kmht_slot_mem.sv
rtl/core/kmht_ctrl.sv
rtl/core/keyed_min_heap_timer_core.sv
verif/tb_top.sv
